@@ rtl/core/pad_pkg.sv @@
package pad_pkg;

	// history and identifier sizing
	localparam int HISTORY_DEPTH = 8;
	localparam int ID_CAPACITY = 9;
	localparam int ID_BYTES = 8;

	// operation codes
	localparam logic [2:0] OP_BAND = 3'd0;
	localparam logic [2:0] OP_SCENE = 3'd1;
	localparam logic [2:0] OP_FINISH = 3'd2;
	localparam logic [2:0] OP_ERROR = 3'd3;
	localparam logic [2:0] OP_AVAIL = 3'd4;

	// status codes
	localparam logic [2:0] ST_EVENT = 3'd0;
	localparam logic [2:0] ST_QUEUED = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_SUPPRESSED = 3'd3;
	localparam logic [2:0] ST_REJECTED = 3'd4;
	localparam logic [2:0] ST_UNAVAILABLE = 3'd5;

	// band and scene codes
	localparam logic [1:0] BAND_UNKNOWN = 2'd3;
	localparam logic [7:0] SCENE_FIRST = 8'd4;
	localparam logic [7:0] SCENE_LAST = 8'd6;

	// identifier punctuation
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_DASH = 8'h2d;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
	} cmd_t;

	// alphanumerics plus colon, underscore and hyphen
	function automatic logic char_ok(input logic [7:0] c);
		logic ok;
		ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a) || c == CH_COLON || c == CH_UNDER || c == CH_DASH;
		return ok;
	endfunction

endpackage

@@ rtl/core/prompt_admission_with_dedup.sv @@
// timing: a transaction taken while idle is captured, then evaluated while busy is high;
// done rises with the registered result, and the receiver cannot stall it
// transactions are taken one at a time through the capture and evaluate steps
// of the controller; a new one is not taken while busy, which is high during the evaluate cycle only
// reset: arst_n clears history fill, playing track, availability and the controller
module prompt_admission_with_dedup #(
	parameter int HISTORY_DEPTH = pad_pkg::HISTORY_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [1:0]  band,
	input  logic [7:0]  scene,
	input  logic [7:0]  track,
	input  logic [63:0] id_text,
	input  logic [3:0]  id_length,
	input  logic        avail_flag,
	output logic        done,
	output logic        accepted,
	output logic        duplicate,
	output logic [7:0]  result_track,
	output logic [2:0]  status,
	output logic        ready_res,
	output logic [7:0]  now_playing
);

	pad_pkg::cmd_t cmd;

	// sequencing
	pad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// checks, history and player state
	pad_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.band         (band),
		.scene        (scene),
		.track        (track),
		.id_text      (id_text),
		.id_length    (id_length),
		.avail_flag   (avail_flag),
		.accepted     (accepted),
		.duplicate    (duplicate),
		.result_track (result_track),
		.status       (status),
		.ready_res    (ready_res),
		.now_playing  (now_playing)
	);

endmodule

@@ rtl/core/pad_ctrl.sv @@
module pad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output pad_pkg::cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	state_t state_q;
	logic done_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// commands
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.eval = (state_q == S_EVAL);
	assign busy = (state_q == S_EVAL);
	assign done = done_q;

endmodule

@@ rtl/core/pad_datapath.sv @@
module pad_datapath #(
	parameter int HISTORY_DEPTH = pad_pkg::HISTORY_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pad_pkg::cmd_t   cmd,
	input  logic [2:0]      op,
	input  logic [1:0]      band,
	input  logic [7:0]      scene,
	input  logic [7:0]      track,
	input  logic [63:0]     id_text,
	input  logic [3:0]      id_length,
	input  logic            avail_flag,
	output logic            accepted,
	output logic            duplicate,
	output logic [7:0]      result_track,
	output logic [2:0]      status,
	output logic            ready_res,
	output logic [7:0]      now_playing
);

	localparam int FillW = $clog2(HISTORY_DEPTH + 1);

	// captured transaction
	logic [2:0]  op_s1;
	logic [7:0]  track_s1;
	logic [63:0] key_s1;
	logic        ok_s1;
	logic        flag_s1;

	// block state
	logic [63:0]      hist_q [HISTORY_DEPTH];
	logic [FillW-1:0] fill_q;
	logic [7:0]       playing_q;
	logic             avail_q;

	// result registers
	logic       acc_q;
	logic       dup_q;
	logic [7:0] rtrack_q;
	logic [2:0] status_q;

	// request check at capture
	logic        len_ok;
	logic        chars_ok;
	logic        track_ok;
	logic [63:0] key_d;

	always_comb begin
		len_ok = (id_length >= 4'd1) && (id_length <= 4'(pad_pkg::ID_CAPACITY - 1));
		chars_ok = 1'b1;
		key_d = '0;
		for (int i = 0; i < pad_pkg::ID_BYTES; i++) begin
			if (4'(i) < id_length) begin
				if (!pad_pkg::char_ok(id_text[63 - 8 * i -: 8])) chars_ok = 1'b0;
				key_d[63 - 8 * i -: 8] = id_text[63 - 8 * i -: 8];
			end
		end
		case (op)
			pad_pkg::OP_BAND:
				track_ok = (band != pad_pkg::BAND_UNKNOWN) && (track == ({6'd0, band} + 8'd1));
			pad_pkg::OP_SCENE:
				track_ok = (scene inside {[pad_pkg::SCENE_FIRST:pad_pkg::SCENE_LAST]}) &&
					(track == scene);
			default:
				track_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1 <= op;
			track_s1 <= track;
			key_s1 <= key_d;
			ok_s1 <= track_ok && len_ok && chars_ok;
			flag_s1 <= avail_flag;
		end
	end

	// history lookup over filled entries
	logic hit;
	logic full;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (FillW'(i) < fill_q && hist_q[i] == key_s1) hit = 1'b1;
		end
	end

	assign full = (fill_q == FillW'(HISTORY_DEPTH));

	// decision
	logic       is_req;
	logic       commit;
	logic       acc_d;
	logic       dup_d;
	logic [7:0] rtrack_d;
	logic [2:0] status_d;
	logic [7:0] playing_d;
	logic       avail_d;

	always_comb begin
		is_req = (op_s1 == pad_pkg::OP_BAND) || (op_s1 == pad_pkg::OP_SCENE);
		commit = 1'b0;
		acc_d = 1'b0;
		dup_d = 1'b0;
		rtrack_d = 8'd0;
		status_d = pad_pkg::ST_EVENT;
		playing_d = playing_q;
		avail_d = avail_q;
		if (is_req) begin
			if (!ok_s1) begin
				status_d = pad_pkg::ST_REJECTED;
			end else begin
				rtrack_d = track_s1;
				if (hit) begin
					acc_d = 1'b1;
					dup_d = 1'b1;
					status_d = pad_pkg::ST_DUPLICATE;
				end else if (!avail_q) begin
					status_d = pad_pkg::ST_UNAVAILABLE;
				end else if (playing_q > track_s1) begin
					status_d = pad_pkg::ST_SUPPRESSED;
				end else begin
					commit = 1'b1;
					playing_d = track_s1;
					acc_d = 1'b1;
					status_d = pad_pkg::ST_QUEUED;
				end
			end
		end else begin
			case (op_s1)
				pad_pkg::OP_FINISH: begin
					if (playing_q == track_s1) playing_d = 8'd0;
				end
				pad_pkg::OP_ERROR: begin
					avail_d = 1'b0;
					playing_d = 8'd0;
				end
				pad_pkg::OP_AVAIL: begin
					avail_d = flag_s1;
					if (!flag_s1) playing_d = 8'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			playing_q <= 8'd0;
			avail_q <= 1'b0;
		end else if (cmd.eval) begin
			playing_q <= playing_d;
			avail_q <= avail_d;
			if (commit && !full) fill_q <= fill_q + FillW'(1);
		end
	end

	// history entries: append while filling, shift down once full
	for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
		always_ff @(posedge clk) begin
			if (cmd.eval && commit) begin
				if (full) begin
					if (g == HISTORY_DEPTH - 1) hist_q[g] <= key_s1;
					else hist_q[g] <= hist_q[(g + 1) % HISTORY_DEPTH];
				end else if (fill_q == FillW'(g)) begin
					hist_q[g] <= key_s1;
				end
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			acc_q <= acc_d;
			dup_q <= dup_d;
			rtrack_q <= rtrack_d;
			status_q <= status_d;
		end
	end

	assign accepted = acc_q;
	assign duplicate = dup_q;
	assign result_track = rtrack_q;
	assign status = status_q;
	assign ready_res = avail_q;
	assign now_playing = playing_q;

endmodule

@@ rtl/core/pad_checker.sv @@
module pad_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       accepted,
	input logic       duplicate,
	input logic [2:0] status,
	input logic       ready_res,
	input logic [7:0] now_playing
);

	// an accepted transaction makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// every busy cycle ends in exactly one result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("busy cycle not followed by result");

	// accepted results are queued or duplicate only
	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> status == pad_pkg::ST_QUEUED || status == pad_pkg::ST_DUPLICATE)
		else $error("accepted with wrong status");

	// duplicate flag agrees with status
	a_dup_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> duplicate == (status == pad_pkg::ST_DUPLICATE))
		else $error("duplicate flag and status disagree");

	// nothing plays while the player is unavailable
	a_idle_unavail: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ready_res |-> now_playing == 8'd0)
		else $error("track playing while unavailable");

endmodule

bind prompt_admission_with_dedup pad_checker u_pad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.accepted    (accepted),
	.duplicate   (duplicate),
	.status      (status),
	.ready_res   (ready_res),
	.now_playing (now_playing)
);
